>>> src/ctc_pkg.sv
// ctc_pkg: shared types and constants of the config token classifier.
// Used by ctc_lexer and config_token_classifier_unit; no dependencies.
package ctc_pkg;

    // Number recognizer phases, one-hot.
    typedef enum logic [12:0] {
        PH_START = 13'b0_0000_0000_0001,
        PH_SIGN  = 13'b0_0000_0000_0010,
        PH_ZERO  = 13'b0_0000_0000_0100,
        PH_HEX0  = 13'b0_0000_0000_1000,
        PH_HEX   = 13'b0_0000_0001_0000,
        PH_OCT   = 13'b0_0000_0010_0000,
        PH_DEC   = 13'b0_0000_0100_0000,
        PH_POINT = 13'b0_0000_1000_0000,
        PH_FRAC  = 13'b0_0001_0000_0000,
        PH_EXP   = 13'b0_0010_0000_0000,
        PH_ESIGN = 13'b0_0100_0000_0000,
        PH_EDIG  = 13'b0_1000_0000_0000,
        PH_DEAD  = 13'b1_0000_0000_0000
    } t_phase;

    typedef enum logic [2:0] {
        CLS_UNKNOWN = 3'd0,
        CLS_INT     = 3'd1,
        CLS_FLOAT   = 3'd2,
        CLS_BOOL    = 3'd3,
        CLS_STRING  = 3'd4
    } t_class;

    localparam int unsigned CHAR_W  = 8;
    localparam int unsigned CNT_W   = 3;
    localparam int unsigned NWORDS  = 6;
    localparam int unsigned WORD_SZ = 8;
    localparam logic [CNT_W-1:0] CNT_MAX = 3'd6;

    // Per-token lexer state.
    typedef struct packed {
        t_phase             phase;
        logic [CNT_W-1:0]   cnt;       // bytes seen, saturates at six
        logic [NWORDS-1:0]  mask;      // boolean words still matching
        logic               first_tf;  // first byte was t, T, f or F
        logic               reserved;  // separator byte seen
    } t_lex_state;

    localparam t_lex_state LEX_RESET = '{
        phase:    PH_START,
        cnt:      '0,
        mask:     '1,
        first_tf: 1'b0,
        reserved: 1'b0
    };

    // Boolean words, padded with zero bytes: true True TRUE false False FALSE.
    localparam logic [CHAR_W-1:0] BOOL_WORDS [NWORDS][WORD_SZ] = '{
        '{8'h74, 8'h72, 8'h75, 8'h65, 8'h00, 8'h00, 8'h00, 8'h00},
        '{8'h54, 8'h72, 8'h75, 8'h65, 8'h00, 8'h00, 8'h00, 8'h00},
        '{8'h54, 8'h52, 8'h55, 8'h45, 8'h00, 8'h00, 8'h00, 8'h00},
        '{8'h66, 8'h61, 8'h6C, 8'h73, 8'h65, 8'h00, 8'h00, 8'h00},
        '{8'h46, 8'h61, 8'h6C, 8'h73, 8'h65, 8'h00, 8'h00, 8'h00},
        '{8'h46, 8'h41, 8'h4C, 8'h53, 8'h45, 8'h00, 8'h00, 8'h00}
    };

    localparam logic [CNT_W-1:0] BOOL_LENS [NWORDS] = '{
        3'd4, 3'd4, 3'd4, 3'd5, 3'd5, 3'd5
    };

endpackage

>>> src/ctc_lexer.sv
// ctc_lexer: one-byte state update and token classification, combinational.
// Depends on ctc_pkg.
module ctc_lexer
    import ctc_pkg::*;
(
    input  t_lex_state        i_state,
    input  logic [CHAR_W-1:0] i_char,
    input  logic              i_last,
    input  logic              i_empty,
    output t_lex_state        o_state,
    output logic              o_done,
    output t_class            o_class
);

    function automatic logic is_dec(input logic [CHAR_W-1:0] c);
        return (c >= 8'h30) && (c <= 8'h39);
    endfunction

    function automatic logic is_oct(input logic [CHAR_W-1:0] c);
        return (c >= 8'h30) && (c <= 8'h37);
    endfunction

    function automatic logic is_hex(input logic [CHAR_W-1:0] c);
        return is_dec(c) || ((c >= 8'h61) && (c <= 8'h66)) || ((c >= 8'h41) && (c <= 8'h46));
    endfunction

    function automatic logic is_expch(input logic [CHAR_W-1:0] c);
        return (c == 8'h64) || (c == 8'h44) || (c == 8'h65) || (c == 8'h45);
    endfunction

    function automatic logic is_sign(input logic [CHAR_W-1:0] c);
        return (c == 8'h2B) || (c == 8'h2D);
    endfunction

    function automatic logic is_ws(input logic [CHAR_W-1:0] c);
        return (c == 8'h20) || (c == 8'h09);
    endfunction

    function automatic logic is_reserved(input logic [CHAR_W-1:0] c);
        return (c == 8'h20) || (c == 8'h3D) || (c == 8'h7B) || (c == 8'h7D) ||
               (c == 8'h2C) || (c == 8'h22) || (c == 8'h3B) || (c == 8'h09);
    endfunction

    // first byte of the mantissa, after optional whitespace and sign
    function automatic t_phase mant_start(input logic [CHAR_W-1:0] c);
        t_phase p;
        if (c == 8'h30)       p = PH_ZERO;
        else if (is_dec(c))   p = PH_DEC;
        else if (c == 8'h2E)  p = PH_POINT;
        else if (is_expch(c)) p = PH_EXP;
        else                  p = PH_DEAD;
        return p;
    endfunction

    function automatic t_class classify(input t_lex_state s);
        t_class cls;
        logic   word_hit;
        word_hit = 1'b0;
        for (int w = 0; w < NWORDS; w++) begin
            if (s.mask[w] && (s.cnt == BOOL_LENS[w])) word_hit = 1'b1;
        end
        unique case (s.phase) inside
            PH_ZERO, PH_HEX, PH_OCT, PH_DEC: cls = CLS_INT;
            PH_POINT, PH_FRAC, PH_EDIG:      cls = CLS_FLOAT;
            default: begin
                if ((s.first_tf && (s.cnt == 3'd1)) || word_hit) cls = CLS_BOOL;
                else if (s.reserved)                              cls = CLS_UNKNOWN;
                else                                              cls = CLS_STRING;
            end
        endcase
        return cls;
    endfunction

    t_phase     ph_nxt;
    t_lex_state taken;

    always_comb begin
        unique case (i_state.phase)
            PH_START: begin
                if (is_ws(i_char))        ph_nxt = PH_START;
                else if (is_sign(i_char)) ph_nxt = PH_SIGN;
                else                      ph_nxt = mant_start(i_char);
            end
            PH_SIGN: ph_nxt = mant_start(i_char);
            PH_ZERO: begin
                if ((i_char == 8'h78) || (i_char == 8'h58)) ph_nxt = PH_HEX0;
                else if (i_char == 8'h2E)                    ph_nxt = PH_POINT;
                else if (is_oct(i_char))                     ph_nxt = PH_OCT;
                else                                         ph_nxt = PH_DEAD;
            end
            PH_HEX0, PH_HEX: ph_nxt = is_hex(i_char) ? PH_HEX : PH_DEAD;
            PH_OCT:          ph_nxt = is_oct(i_char) ? PH_OCT : PH_DEAD;
            PH_DEC: begin
                if (is_dec(i_char))        ph_nxt = PH_DEC;
                else if (i_char == 8'h2E)  ph_nxt = PH_POINT;
                else if (is_expch(i_char)) ph_nxt = PH_EXP;
                else                       ph_nxt = PH_DEAD;
            end
            PH_POINT, PH_FRAC: begin
                if (is_dec(i_char))        ph_nxt = PH_FRAC;
                else if (is_expch(i_char)) ph_nxt = PH_EXP;
                else                       ph_nxt = PH_DEAD;
            end
            PH_EXP: begin
                if (is_sign(i_char))      ph_nxt = PH_ESIGN;
                else if (is_dec(i_char))  ph_nxt = PH_EDIG;
                else                      ph_nxt = PH_DEAD;
            end
            PH_ESIGN, PH_EDIG: ph_nxt = is_dec(i_char) ? PH_EDIG : PH_DEAD;
            default:           ph_nxt = PH_DEAD;
        endcase
    end

    always_comb begin
        taken       = i_state;
        taken.phase = ph_nxt;
        if ((i_state.cnt == '0) &&
            ((i_char == 8'h74) || (i_char == 8'h54) || (i_char == 8'h66) || (i_char == 8'h46)))
            taken.first_tf = 1'b1;
        for (int w = 0; w < NWORDS; w++) begin
            if ((i_state.cnt >= BOOL_LENS[w]) || (i_char != BOOL_WORDS[w][i_state.cnt]))
                taken.mask[w] = 1'b0;
        end
        if (is_reserved(i_char)) taken.reserved = 1'b1;
        if (i_state.cnt < CNT_MAX) taken.cnt = i_state.cnt + 3'd1;
    end

    // empty_token ends the token without the current byte
    assign o_done  = i_empty || i_last;
    assign o_class = classify(i_empty ? i_state : taken);
    assign o_state = o_done ? LEX_RESET : taken;

endmodule

>>> src/config_token_classifier_unit.sv
// config_token_classifier_unit: top level of the token classifier.
// Depends on ctc_pkg and ctc_lexer.
//
//  channel  | dir | tdata                     | tlast           | tuser
//  ---------+-----+---------------------------+-----------------+-------------------
//  s_axis   | in  | [7:0] character           | last byte       | [0] empty_token
//  m_axis   | out | [2:0] token_class, [7:3]0 | -               | -
//
// One byte word per cycle in while the input is not stalled; one class word per token out.
// Path: input register, then lexer update into the output register. A word
// that ends a token moves on only when the output register is free or being
// drained; any other word is not held by the output.
// Reset (synchronous, active low) empties both stages and starts a new token.
// A stalled output holds its word and stalls the input only when the word
// in the input register would end a token.
module config_token_classifier_unit
    import ctc_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] character
    input  logic        s_axis_tlast,   // last byte of token
    input  logic        s_axis_tuser,   // [0] empty_token
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [7:0]  m_axis_tdata    // [2:0] token_class, [7:3] zero
);

    // input register
    logic              r_in_valid;
    logic [CHAR_W-1:0] r_char;
    logic              r_last;
    logic              r_empty;

    // running token state
    t_lex_state r_state;
    t_lex_state n_state;

    // output register
    logic   r_out_valid;
    t_class r_out_class;

    logic   lex_done;
    t_class lex_class;
    logic   out_free;
    logic   adv;

    ctc_lexer u_lexer (
        .i_state (r_state),
        .i_char  (r_char),
        .i_last  (r_last),
        .i_empty (r_empty),
        .o_state (n_state),
        .o_done  (lex_done),
        .o_class (lex_class)
    );

    assign out_free      = !r_out_valid || m_axis_tready;
    // the held word is consumed unless it ends a token into a full output
    assign adv           = r_in_valid && (!lex_done || out_free);
    assign s_axis_tready = !r_in_valid || adv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (s_axis_tvalid && s_axis_tready) begin
            r_in_valid <= 1'b1;
        end else if (adv) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tvalid && s_axis_tready) begin
            r_char  <= s_axis_tdata;
            r_last  <= s_axis_tlast;
            r_empty <= s_axis_tuser;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= LEX_RESET;
        end else if (adv) begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (adv && lex_done) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv && lex_done) begin
            r_out_class <= lex_class;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {5'd0, r_out_class};

endmodule

>>> src/ctc_checker.sv
// ctc_checker: port-level assertions for config_token_classifier_unit.
// Standalone; bound to the top level at the end of this file.
module ctc_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       s_axis_tvalid,
    input logic       s_axis_tready,
    input logic [7:0] s_axis_tdata,
    input logic       s_axis_tlast,
    input logic       s_axis_tuser,
    input logic       m_axis_tvalid,
    input logic       m_axis_tready,
    input logic [7:0] m_axis_tdata
);

    // a stalled class word stays put
    a_out_hold_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
        else $error("m_axis_tvalid dropped while stalled");

    a_out_hold_data: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata))
        else $error("m_axis_tdata changed while stalled");

    // class code in range and padding bits clear
    a_class_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> (m_axis_tdata[7:3] == 5'd0) && (m_axis_tdata[2:0] <= 3'd4))
        else $error("bad token class word");

    // a draining output never blocks the input side
    a_ready_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tready |-> s_axis_tready)
        else $error("input stalled while output drains");

    // reset leaves no class word pending
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid)
        else $error("class word pending after reset");

endmodule

bind config_token_classifier_unit ctc_checker u_ctc_checker (.*);

>>> tb/tb_config_token_classifier_unit.sv
// Self-checking testbench for config_token_classifier_unit: streams tokens byte by byte and
// compares every class word with a built-in lexer model.
// Depends on ctc_pkg (phase and class enums) and the unit itself.
module tb_config_token_classifier_unit
    import ctc_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    localparam int unsigned CYCLE_LIMIT  = 400000;  // far above the slowest legal run
    localparam int          RAND_ITEMS   = 1150;    // bytes in the random part
    localparam int          TAIL_CYCLES  = 20;      // settle time after the last word
    localparam int          MAX_REPORTS  = 200;     // keep the log readable on a bad RTL

    // ------------------------------------------------------------------
    // DUT connections
    // ------------------------------------------------------------------
    logic        i_clk = 1'b0;
    logic        i_rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata;   // [7:0] character
    logic        s_axis_tlast;   // last byte of token
    logic        s_axis_tuser;   // [0] empty_token
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [7:0]  m_axis_tdata;   // [2:0] token_class, [7:3] zero

    config_token_classifier_unit u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    // 20 ns clock
    initial begin
        forever #10 i_clk = ~i_clk;
    end

    // ------------------------------------------------------------------
    // Shared bench state
    // ------------------------------------------------------------------
    t_class      pending_classes [$];   // class words still owed by the DUT
    logic [7:0]  tok [$];               // token being built for transmission
    int          err_cnt   = 0;
    int          bytes_sent = 0;        // accepted input words
    int unsigned cycle_cnt = 0;
    bit          idle_en   = 1'b1;      // random gaps / stalls on both sides

    string bool_words [6] = '{"true", "True", "TRUE", "false", "False", "FALSE"};
    string near_words [10] = '{"t", "T", "f", "F", "tru", "fals", "truex", "FALSEe",
                               "tRUE", "fAlse"};
    string digit_set = "0123456789abcdefABCDEF";
    string exp_set   = "dDeE";
    string sep_set   = " ={},;\"";

    // ------------------------------------------------------------------
    // Lexer model: its own copy of the per-token state
    // ------------------------------------------------------------------
    t_phase      lex_phase;
    logic [2:0]  lex_cnt;       // bytes seen, sticks at six
    logic [5:0]  lex_words;     // boolean words still matching
    logic        lex_tf;        // token began with t, T, f or F
    logic        lex_sep;       // separator byte seen

    function automatic bit is_dec(logic [7:0] c);
        return c >= "0" && c <= "9";
    endfunction

    function automatic bit is_oct(logic [7:0] c);
        return c >= "0" && c <= "7";
    endfunction

    function automatic bit is_hex(logic [7:0] c);
        return is_dec(c) || (c >= "a" && c <= "f") || (c >= "A" && c <= "F");
    endfunction

    function automatic bit is_exp(logic [7:0] c);
        return c == "d" || c == "D" || c == "e" || c == "E";
    endfunction

    function automatic bit is_sign(logic [7:0] c);
        return c == "+" || c == "-";
    endfunction

    function automatic bit is_ws(logic [7:0] c);
        return c == " " || c == 8'h09;
    endfunction

    function automatic bit is_sep(logic [7:0] c);
        return is_ws(c) || c == "=" || c == "{" || c == "}" || c == "," ||
               c == 8'h22 || c == ";";
    endfunction

    // first byte of a mantissa, after optional whitespace and sign
    function automatic t_phase mantissa_start(logic [7:0] c);
        if (c == "0") return PH_ZERO;
        if (is_dec(c)) return PH_DEC;
        if (c == ".") return PH_POINT;
        if (is_exp(c)) return PH_EXP;
        return PH_DEAD;
    endfunction

    function automatic t_phase phase_next(t_phase p, logic [7:0] c);
        case (p)
            PH_START: begin
                if (is_ws(c)) return PH_START;
                if (is_sign(c)) return PH_SIGN;
                return mantissa_start(c);
            end
            PH_SIGN: return mantissa_start(c);
            PH_ZERO: begin
                if (c == "x" || c == "X") return PH_HEX0;
                if (c == ".") return PH_POINT;
                return is_oct(c) ? PH_OCT : PH_DEAD;
            end
            PH_HEX0, PH_HEX: return is_hex(c) ? PH_HEX : PH_DEAD;
            PH_OCT: return is_oct(c) ? PH_OCT : PH_DEAD;
            PH_DEC: begin
                if (is_dec(c)) return PH_DEC;
                if (c == ".") return PH_POINT;
                return is_exp(c) ? PH_EXP : PH_DEAD;
            end
            PH_POINT, PH_FRAC: begin
                if (is_dec(c)) return PH_FRAC;
                return is_exp(c) ? PH_EXP : PH_DEAD;
            end
            PH_EXP: begin
                if (is_sign(c)) return PH_ESIGN;
                return is_dec(c) ? PH_EDIG : PH_DEAD;
            end
            PH_ESIGN, PH_EDIG: return is_dec(c) ? PH_EDIG : PH_DEAD;
            default: return PH_DEAD;
        endcase
    endfunction

    function automatic void lex_clear();
        lex_phase = PH_START;
        lex_cnt   = 3'd0;
        lex_words = 6'h3F;
        lex_tf    = 1'b0;
        lex_sep   = 1'b0;
    endfunction

    function automatic void lex_take(logic [7:0] c);
        lex_phase = phase_next(lex_phase, c);
        if (lex_cnt == 3'd0 && (c == "t" || c == "T" || c == "f" || c == "F"))
            lex_tf = 1'b1;
        for (int w = 0; w < 6; w++) begin
            if (int'(lex_cnt) >= bool_words[w].len() ||
                c != 8'(bool_words[w][lex_cnt]))
                lex_words[w] = 1'b0;
        end
        if (is_sep(c))
            lex_sep = 1'b1;
        if (lex_cnt < 3'd6)
            lex_cnt = lex_cnt + 3'd1;
    endfunction

    function automatic t_class lex_class();
        case (lex_phase)
            PH_ZERO, PH_HEX, PH_OCT, PH_DEC: return CLS_INT;
            PH_POINT, PH_FRAC, PH_EDIG:      return CLS_FLOAT;
            default: ;
        endcase
        // a lone t/T/f/F counts as a boolean
        if (lex_tf && lex_cnt == 3'd1)
            return CLS_BOOL;
        for (int w = 0; w < 6; w++) begin
            if (lex_words[w] && int'(lex_cnt) == bool_words[w].len())
                return CLS_BOOL;
        end
        return lex_sep ? CLS_UNKNOWN : CLS_STRING;
    endfunction

    // Book-keeping for one accepted word. An empty_token word ignores its
    // byte and its tlast and closes the token as it stands.
    function automatic void lex_accept(logic [7:0] c, logic last, logic empty);
        if (!empty)
            lex_take(c);
        if (empty || last) begin
            pending_classes.push_back(lex_class());
            lex_clear();
        end
    endfunction

    // ------------------------------------------------------------------
    // Source side
    // ------------------------------------------------------------------
    // Presents one word and returns right after the edge that took it.
    // tvalid stays high between back-to-back words; a gap lowers it first.
    task automatic send_char(logic [7:0] c, logic last, logic empty);
        if (idle_en && $urandom_range(0, 3) == 0) begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 9)) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= c;
        s_axis_tlast  <= last;
        s_axis_tuser  <= empty;
        do @(posedge i_clk); while (!s_axis_tready);
        lex_accept(c, last, empty);
        bytes_sent++;
    endtask

    // Sends tok[]; the token ends on tlast of its last byte, or on a trailing
    // empty_token word (always used when tok[] is empty).
    task automatic send_tok(bit by_empty);
        for (int i = 0; i < tok.size(); i++)
            send_char(tok[i], (i == tok.size() - 1) && !by_empty, 1'b0);
        if (by_empty || tok.size() == 0)
            send_char(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)), 1'b1);
    endtask

    task automatic send_text(string s, bit by_empty);
        tok.delete();
        for (int i = 0; i < s.len(); i++)
            tok.push_back(8'(s[i]));
        send_tok(by_empty);
    endtask

    // Stops the source until every class word owed has come back.
    task automatic drain_results();
        s_axis_tvalid <= 1'b0;
        do @(posedge i_clk); while (pending_classes.size() != 0);
    endtask

    // ------------------------------------------------------------------
    // Random token builders
    // ------------------------------------------------------------------
    function automatic logic [7:0] pick_digit(int radix);
        int top;
        top = (radix == 8) ? 7 : (radix == 10) ? 9 : 21;
        return 8'(digit_set[$urandom_range(0, top)]);
    endfunction

    function automatic logic [7:0] pick_plain();
        logic [7:0] c;
        do c = 8'($urandom_range(33, 126)); while (is_sep(c));
        return c;
    endfunction

    // optional whitespace run, then optional sign
    function automatic void add_lead();
        if ($urandom_range(0, 3) == 0)
            repeat ($urandom_range(1, 2)) tok.push_back($urandom_range(0, 1) ? " " : 8'h09);
        if ($urandom_range(0, 2) == 0)
            tok.push_back($urandom_range(0, 1) ? "+" : "-");
    endfunction

    function automatic void add_digits(int radix, int lo, int hi);
        repeat ($urandom_range(lo, hi)) tok.push_back(pick_digit(radix));
    endfunction

    function automatic void add_float();
        add_lead();
        add_digits(10, 0, 3);
        if ($urandom_range(0, 1)) begin
            tok.push_back(".");
            add_digits(10, 0, 3);
        end
        if ($urandom_range(0, 1)) begin
            tok.push_back(8'(exp_set[$urandom_range(0, 3)]));
            if ($urandom_range(0, 1))
                tok.push_back($urandom_range(0, 1) ? "+" : "-");
            add_digits(10, 0, 2);
        end
    endfunction

    function automatic void put_word(string s);
        for (int i = 0; i < s.len(); i++)
            tok.push_back(8'(s[i]));
    endfunction

    // Mostly well-formed numbers and words with random content; the rest is
    // noise, broken numbers and separator-heavy tokens.
    function automatic void build_token();
        int pos;
        tok.delete();
        case ($urandom_range(0, 11))
            0, 1: begin
                add_lead();
                add_digits(10, 1, 5);
            end
            2: begin
                add_lead();
                tok.push_back("0");
                tok.push_back($urandom_range(0, 1) ? "x" : "X");
                add_digits(16, 0, 4);
            end
            3: begin
                add_lead();
                tok.push_back("0");
                add_digits(8, 0, 4);
            end
            4, 5: add_float();
            6: begin
                if ($urandom_range(0, 1))
                    put_word(bool_words[$urandom_range(0, 5)]);
                else
                    put_word(near_words[$urandom_range(0, 9)]);
            end
            7: repeat ($urandom_range(1, 6)) tok.push_back(pick_plain());
            8: repeat ($urandom_range(1, 6)) tok.push_back(8'($urandom_range(0, 255)));
            9, 10: begin
                // well-formed float with one byte spoiled
                add_float();
                if (tok.size() != 0) begin
                    pos = $urandom_range(0, tok.size() - 1);
                    tok[pos] = 8'($urandom_range(0, 255));
                end
            end
            default: begin
                // whitespace and separators mixed with a few plain bytes
                repeat ($urandom_range(1, 5)) begin
                    case ($urandom_range(0, 3))
                        0: tok.push_back(" ");
                        1: tok.push_back(8'h09);
                        2: tok.push_back(8'(sep_set[$urandom_range(0, 6)]));
                        default: tok.push_back(pick_plain());
                    endcase
                end
            end
        endcase
    endfunction

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------
    // integer forms, hex/octal edges, float shapes
    task automatic test_numbers();
        send_text("0x", 1'b0);          // bare hex prefix: string
        send_text("0XaF", 1'b0);
        send_text("017", 1'b0);
        send_text("09", 1'b0);          // non-octal after leading zero
        send_text("\t-12", 1'b0);
        send_text("+.5", 1'b0);         // float without mantissa digits
        send_text(".", 1'b0);
        send_text("e5", 1'b0);
        send_text("1.5E-3", 1'b0);
        send_text("2d+", 1'b0);         // exponent with no digits
        send_text("9999999", 1'b0);     // byte count saturates
        drain_results();
    endtask

    // booleans, near misses, strings and separators
    task automatic test_words();
        foreach (bool_words[w])
            send_text(bool_words[w], 1'b0);
        send_text("F", 1'b0);
        send_text("fals", 1'b0);
        send_text("foo", 1'b0);
        send_text("a=b", 1'b0);
        send_text(" ", 1'b0);           // whitespace only: unknown
        drain_results();
    endtask

    // empty tokens, both flags, zero and top byte values
    task automatic test_special_cases();
        send_char(8'hFF, 1'b0, 1'b1);   // empty token straight away
        send_text("12", 1'b1);          // bytes closed by an empty_token word
        send_char("1", 1'b0, 1'b0);
        send_char("x", 1'b1, 1'b1);     // both flags: byte is dropped
        tok.delete();
        tok.push_back("7");
        tok.push_back(8'h00);
        send_tok(1'b0);
        tok.delete();
        tok.push_back(8'h00);
        send_tok(1'b0);
        drain_results();
    endtask

    // long random run: a quiet stretch early on, one full drain halfway,
    // and no gaps or stalls at all over the last stretch
    task automatic test_random_tokens();
        int  base;
        int  done;
        bit  paused;
        base   = bytes_sent;
        paused = 1'b0;
        done   = 0;
        while (done < RAND_ITEMS) begin
            if (!paused && done >= RAND_ITEMS / 2) begin
                drain_results();
                paused = 1'b1;
            end
            idle_en = !((done >= 300 && done < 420) || done >= RAND_ITEMS * 85 / 100);
            build_token();
            send_tok($urandom_range(0, 7) == 0);
            done = bytes_sent - base;
        end
        drain_results();
    endtask

    // ------------------------------------------------------------------
    // Sink side: random stall bursts while idling is on
    // ------------------------------------------------------------------
    initial begin
        int stall_left;
        stall_left = 0;
        m_axis_tready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (stall_left > 0) begin
                stall_left--;
                m_axis_tready <= 1'b0;
            end else if (idle_en && $urandom_range(0, 4) == 0) begin
                stall_left = $urandom_range(0, 8);
                m_axis_tready <= 1'b0;
            end else begin
                m_axis_tready <= 1'b1;
            end
        end
    end

    // ------------------------------------------------------------------
    // Result check: each accepted word against the oldest owed class
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        t_class want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (pending_classes.size() == 0) begin
                if (err_cnt < MAX_REPORTS)
                    $error("token_class: expected none, actual %0d", m_axis_tdata[2:0]);
                err_cnt++;
            end else begin
                want = pending_classes.pop_front();
                if (m_axis_tdata[2:0] != want) begin
                    if (err_cnt < MAX_REPORTS)
                        $error("token_class: expected %0d, actual %0d",
                               want, m_axis_tdata[2:0]);
                    err_cnt++;
                end
                if (m_axis_tdata[7:3] != 5'd0) begin
                    if (err_cnt < MAX_REPORTS)
                        $error("tdata pad: expected 0, actual %0d", m_axis_tdata[7:3]);
                    err_cnt++;
                end
            end
        end
    end

    // watchdog
    always @(posedge i_clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt == CYCLE_LIMIT) begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------
    initial begin
        i_rst_n       <= 1'b0;
        s_axis_tvalid <= 1'b0;
        s_axis_tdata  <= 8'h00;
        s_axis_tlast  <= 1'b0;
        s_axis_tuser  <= 1'b0;
        lex_clear();
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_numbers();
        test_words();
        test_special_cases();
        test_random_tokens();

        // nothing owed any more; give a stray word time to show up
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (err_cnt == 0 && pending_classes.size() == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule

>>> sim.f
src/ctc_pkg.sv
src/ctc_lexer.sv
src/config_token_classifier_unit.sv
src/ctc_checker.sv
tb/tb_config_token_classifier_unit.sv
